### sv/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the triangle tangent basis block
// Payload structs, the link types between the sequencer and the shared
// divide/root unit, and the saturation helpers.
// ----------------------------------------------------------------------------
package ttb_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } ttb_in_t;

  typedef struct packed {
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
    logic signed [31:0] bitan_x;
    logic signed [31:0] bitan_y;
    logic signed [31:0] bitan_z;
    logic               degenerate;
    logic               last;
  } ttb_out_t;

  typedef struct packed {
    ttb_in_t [2:0] vtx;
  } ttb_tri_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd32;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } ds_op_t;

  typedef struct packed {
    logic        start;
    ds_op_t      op;
    logic [64:0] rem0;
    logic [31:0] low;
    logic [64:0] divisor;
    logic [5:0]  steps;
  } ds_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] result;
  } ds_rsp_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_LD,
    WB_ADD,
    WB_SUB,
    WB_LD_SH,
    WB_ADD_SH,
    WB_U,
    WB_SUBW
  } wb_op_t;

  typedef struct packed {
    wb_op_t     op;
    logic [1:0] idx;
  } mul_tag_t;

  typedef enum logic [4:0] {
    BS_IDLE,
    BS_EDGE,
    BS_DET,
    BS_DET_W,
    BS_DET_CHK,
    BS_NUM,
    BS_NUM_W,
    BS_DIV_GO,
    BS_DIV_WAIT,
    BS_DOT,
    BS_DOT_W,
    BS_DSAT,
    BS_U,
    BS_U_W,
    BS_MAG,
    BS_SHIFT,
    BS_SQ,
    BS_SQ_W,
    BS_SQ_CHK,
    BS_SQRT,
    BS_NRM_GO,
    BS_NRM_WAIT,
    BS_CROSS,
    BS_CROSS_W,
    BS_HAND,
    BS_HAND_W,
    BS_EMIT
  } back_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [65:0] d;
    d = 66'(a) - 66'(b);
    return sat32(d);
  endfunction

endpackage

### sv/ttb_front.sv
// ----------------------------------------------------------------------------
// ttb_front: vertex collector
// Holds the first two vertices of a triangle and pushes the complete
// triangle into the queue when its third vertex arrives.
// ----------------------------------------------------------------------------
module ttb_front import ttb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ttb_in_t  in_data,
  output logic     q_push,
  output ttb_tri_t q_data,
  input  logic     q_full
);

  logic [1:0] slot_r;
  ttb_in_t    v0_r;
  ttb_in_t    v1_r;
  logic       take;

  // Only the closing vertex needs room in the queue.
  assign in_ready = (slot_r != 2'd2) || !q_full;
  assign take     = in_valid && in_ready;
  assign q_push   = take && (slot_r == 2'd2);

  always_comb begin
    q_data.vtx[0] = v0_r;
    q_data.vtx[1] = v1_r;
    q_data.vtx[2] = in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 2'd0;
    end else if (take) begin
      slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && slot_r == 2'd0) begin
      v0_r <= in_data;
    end
    if (take && slot_r == 2'd1) begin
      v1_r <= in_data;
    end
  end

endmodule

### sv/ttb_queue.sv
// ----------------------------------------------------------------------------
// ttb_queue: triangle queue
// A short FIFO of complete triangles between the collector and the
// sequencer.
// ----------------------------------------------------------------------------
module ttb_queue import ttb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ttb_tri_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output ttb_tri_t head
);

  ttb_tri_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/ttb_divsqrt.sv
// ----------------------------------------------------------------------------
// ttb_divsqrt: shared iterative divider and square root
// Restoring division producing one quotient bit per cycle, and a
// bit-pair integer square root producing one root bit per cycle.
// ----------------------------------------------------------------------------
module ttb_divsqrt import ttb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  ds_req_t req,
  output ds_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  ds_op_t      op_r;
  logic [5:0]  cnt_r;
  logic [64:0] rem_r;
  logic [31:0] low_r;
  logic [64:0] div_r;
  logic [31:0] quo_r;
  logic        ovf_r;
  logic [62:0] res_r;
  logic [62:0] bit_r;

  logic [65:0] trial;
  logic        dge;
  logic [63:0] rb;
  logic        sge;

  always_comb begin
    trial = {rem_r, low_r[31]};
    dge   = trial >= {1'b0, div_r};
    rb    = {1'b0, res_r} + {1'b0, bit_r};
    sge   = {2'b00, rem_r[61:0]} >= rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == DS_SQRT) ? SQRT_STEPS : req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      rem_r <= req.rem0;
      low_r <= req.low;
      div_r <= req.divisor;
      quo_r <= '0;
      ovf_r <= req.rem0 >= req.divisor;
      res_r <= '0;
      bit_r <= 63'h1 << 62;
    end else if (busy_r) begin
      if (op_r == DS_DIV) begin
        rem_r <= dge ? 65'(trial - {1'b0, div_r}) : trial[64:0];
        quo_r <= {quo_r[30:0], dge};
        low_r <= {low_r[30:0], 1'b0};
      end else begin
        if (sge) begin
          rem_r <= 65'({2'b00, rem_r[61:0]} - rb);
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  always_comb begin
    rsp.done   = done_r;
    rsp.ovf    = ovf_r;
    rsp.result = (op_r == DS_DIV) ? quo_r : res_r[31:0];
  end

endmodule

### sv/ttb_back.sv
// ----------------------------------------------------------------------------
// ttb_back: tangent basis sequencer
// Takes one triangle from the queue, forms its tangent and bitangent and
// emits the per-vertex orthogonalized tangents through an output register.
// ----------------------------------------------------------------------------
module ttb_back import ttb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  ttb_tri_t q_head,
  output logic     q_pop,
  output ds_req_t  ds_req,
  input  ds_rsp_t  ds_rsp,
  output logic     out_valid,
  input  logic     out_ready,
  output ttb_out_t out_data
);

  localparam int         DIV_SH    = 32 - FRAC_BITS;
  localparam logic [5:0] NRM_STEPS = 6'(FRAC_BITS + 1);

  back_state_t state_r, state_nxt;
  logic [2:0]  cnt_r;
  logic [2:0]  j_r;
  logic [1:0]  k_r;

  ttb_tri_t           tri_r;
  logic signed [31:0] e1_r [3];
  logic signed [31:0] e2_r [3];
  logic signed [31:0] s1_r, t1_r, s2_r, t2_r;
  logic signed [65:0] det_r;
  logic               deg_r;
  logic               qneg_r;
  logic signed [31:0] tg_r [3];
  logic signed [31:0] bt_r [3];
  logic signed [31:0] d_r;
  logic signed [63:0] u_r [3];
  logic [63:0]        m_r [3];
  logic               mneg_r [3];
  logic [30:0]        len_r;
  logic signed [31:0] h_r [3];
  logic signed [31:0] w_r [3];
  logic signed [65:0] acc_r;
  logic signed [63:0] prod_r;
  mul_tag_t           tag_r;
  logic               out_valid_r;
  ttb_out_t           out_r;

  logic signed [31:0] pos [3][3];
  logic signed [31:0] tex [3][2];
  logic signed [31:0] nrm [3][3];
  logic signed [31:0] mul_a, mul_b;
  mul_tag_t           mul_tag;
  logic [1:0]         c_idx;
  logic [1:0]         jc;
  logic [65:0]        un, ud;
  logic [32:0]        lim33, q33, mag33;
  logic signed [31:0] qval;
  logic signed [31:0] nq;
  logic               issue_last;
  logic               out_free;
  logic               big;
  logic signed [63:0] psh;
  logic signed [65:0] subw;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos[k][0] = tri_r.vtx[k].pos_x;
      pos[k][1] = tri_r.vtx[k].pos_y;
      pos[k][2] = tri_r.vtx[k].pos_z;
      tex[k][0] = tri_r.vtx[k].tex_u;
      tex[k][1] = tri_r.vtx[k].tex_v;
      nrm[k][0] = tri_r.vtx[k].norm_x;
      nrm[k][1] = tri_r.vtx[k].norm_y;
      nrm[k][2] = tri_r.vtx[k].norm_z;
    end
  end

  assign c_idx    = cnt_r[1:0];
  assign jc       = (j_r < 3'd3) ? j_r[1:0] : 2'(j_r - 3'd3);
  assign out_free = !out_valid_r || out_ready;
  assign big      = (|m_r[0][63:30]) || (|m_r[1][63:30]) || (|m_r[2][63:30]);
  assign un       = acc_r[65] ? 66'(-acc_r) : 66'(acc_r);
  assign ud       = det_r[65] ? 66'(-det_r) : 66'(det_r);

  // Quotient saturation: the negative side reaches one step further.
  always_comb begin
    lim33 = qneg_r ? 33'd2147483648 : 33'd2147483647;
    q33   = {1'b0, ds_rsp.result};
    mag33 = (ds_rsp.ovf || q33 > lim33) ? lim33 : q33;
    qval  = qneg_r ? $signed(32'(-mag33)) : $signed(32'(mag33));
    nq    = mneg_r[c_idx] ? -$signed(ds_rsp.result) : $signed(ds_rsp.result);
  end

  always_comb begin
    case (state_r)
      BS_DET, BS_NUM: issue_last = (cnt_r == 3'd1);
      BS_CROSS:       issue_last = (cnt_r == 3'd5);
      default:        issue_last = (cnt_r == 3'd2);
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE:     if (!q_empty) state_nxt = BS_EDGE;
      BS_EDGE:     state_nxt = BS_DET;
      BS_DET:      if (issue_last) state_nxt = BS_DET_W;
      BS_DET_W:    state_nxt = BS_DET_CHK;
      BS_DET_CHK:  state_nxt = (acc_r == '0) ? BS_DOT : BS_NUM;
      BS_NUM:      if (issue_last) state_nxt = BS_NUM_W;
      BS_NUM_W:    state_nxt = BS_DIV_GO;
      BS_DIV_GO:   state_nxt = BS_DIV_WAIT;
      BS_DIV_WAIT: if (ds_rsp.done) state_nxt = (j_r == 3'd5) ? BS_DOT : BS_NUM;
      BS_DOT:      if (issue_last) state_nxt = BS_DOT_W;
      BS_DOT_W:    state_nxt = BS_DSAT;
      BS_DSAT:     state_nxt = BS_U;
      BS_U:        if (issue_last) state_nxt = BS_U_W;
      BS_U_W:      state_nxt = BS_MAG;
      BS_MAG:      state_nxt = BS_SHIFT;
      BS_SHIFT:    if (!big) state_nxt = BS_SQ;
      BS_SQ:       if (issue_last) state_nxt = BS_SQ_W;
      BS_SQ_W:     state_nxt = BS_SQ_CHK;
      BS_SQ_CHK:   state_nxt = (acc_r == '0) ? BS_CROSS : BS_SQRT;
      BS_SQRT:     if (ds_rsp.done) state_nxt = BS_NRM_GO;
      BS_NRM_GO:   state_nxt = BS_NRM_WAIT;
      BS_NRM_WAIT: if (ds_rsp.done) state_nxt = (cnt_r == 3'd2) ? BS_CROSS : BS_NRM_GO;
      BS_CROSS:    if (issue_last) state_nxt = BS_CROSS_W;
      BS_CROSS_W:  state_nxt = BS_HAND;
      BS_HAND:     if (issue_last) state_nxt = BS_HAND_W;
      BS_HAND_W:   state_nxt = BS_EMIT;
      BS_EMIT:     if (out_free) state_nxt = (k_r == 2'd2) ? BS_IDLE : BS_DOT;
      default:     state_nxt = BS_IDLE;
    endcase
  end

  // Control outputs: queue pop, divider requests and multiplier issue
  always_comb begin
    q_pop          = (state_r == BS_IDLE) && !q_empty;
    ds_req         = '0;
    ds_req.op      = DS_DIV;
    mul_a          = '0;
    mul_b          = '0;
    mul_tag.op     = WB_NONE;
    mul_tag.idx    = c_idx;
    case (state_r)
      BS_DIV_GO: begin
        ds_req.start   = 1'b1;
        ds_req.rem0    = 65'(un >> DIV_SH);
        ds_req.low     = 32'(un << FRAC_BITS);
        ds_req.divisor = ud[64:0];
        ds_req.steps   = DIV_STEPS;
      end
      BS_SQ_CHK: begin
        ds_req.start = (acc_r != '0);
        ds_req.op    = DS_SQRT;
        ds_req.rem0  = acc_r[64:0];
      end
      BS_NRM_GO: begin
        ds_req.start   = 1'b1;
        ds_req.rem0    = 65'(m_r[c_idx] >> 1);
        ds_req.low     = {m_r[c_idx][0], 31'b0};
        ds_req.divisor = 65'(len_r);
        ds_req.steps   = NRM_STEPS;
      end
      BS_DET: begin
        mul_a      = (cnt_r == 3'd0) ? s1_r : t1_r;
        mul_b      = (cnt_r == 3'd0) ? t2_r : s2_r;
        mul_tag.op = (cnt_r == 3'd0) ? WB_LD : WB_SUB;
      end
      BS_NUM: begin
        if (j_r < 3'd3) begin
          mul_a = (cnt_r == 3'd0) ? e1_r[jc] : e2_r[jc];
          mul_b = (cnt_r == 3'd0) ? t2_r : t1_r;
        end else begin
          mul_a = (cnt_r == 3'd0) ? e2_r[jc] : e1_r[jc];
          mul_b = (cnt_r == 3'd0) ? s1_r : s2_r;
        end
        mul_tag.op = (cnt_r == 3'd0) ? WB_LD : WB_SUB;
      end
      BS_DOT: begin
        mul_a      = nrm[k_r][c_idx];
        mul_b      = tg_r[c_idx];
        mul_tag.op = (cnt_r == 3'd0) ? WB_LD_SH : WB_ADD_SH;
      end
      BS_U: begin
        mul_a      = nrm[k_r][c_idx];
        mul_b      = d_r;
        mul_tag.op = WB_U;
      end
      BS_SQ: begin
        mul_a      = $signed({2'b00, m_r[c_idx][29:0]});
        mul_b      = $signed({2'b00, m_r[c_idx][29:0]});
        mul_tag.op = (cnt_r == 3'd0) ? WB_LD : WB_ADD;
      end
      BS_CROSS: begin
        // Each cross component is a load followed by a subtract.
        case (cnt_r)
          3'd0: begin mul_a = nrm[k_r][1]; mul_b = h_r[2]; end
          3'd1: begin mul_a = nrm[k_r][2]; mul_b = h_r[1]; end
          3'd2: begin mul_a = nrm[k_r][2]; mul_b = h_r[0]; end
          3'd3: begin mul_a = nrm[k_r][0]; mul_b = h_r[2]; end
          3'd4: begin mul_a = nrm[k_r][0]; mul_b = h_r[1]; end
          default: begin mul_a = nrm[k_r][1]; mul_b = h_r[0]; end
        endcase
        mul_tag.op  = cnt_r[0] ? WB_SUBW : WB_LD;
        mul_tag.idx = 2'(cnt_r >> 1);
      end
      BS_HAND: begin
        mul_a      = w_r[c_idx];
        mul_b      = bt_r[c_idx];
        mul_tag.op = (cnt_r == 3'd0) ? WB_LD_SH : WB_ADD_SH;
      end
      default: begin
        mul_tag.op = WB_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      cnt_r       <= '0;
      j_r         <= '0;
      k_r         <= '0;
      tag_r.op    <= WB_NONE;
      tag_r.idx   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tag_r   <= mul_tag;
      case (state_r)
        BS_DET, BS_NUM, BS_DOT, BS_U, BS_SQ, BS_CROSS, BS_HAND:
          cnt_r <= issue_last ? 3'd0 : cnt_r + 3'd1;
        BS_NRM_WAIT:
          if (ds_rsp.done) cnt_r <= (cnt_r == 3'd2) ? 3'd0 : cnt_r + 3'd1;
        default: cnt_r <= cnt_r;
      endcase
      if (state_r == BS_DET_CHK) begin
        j_r <= '0;
        k_r <= '0;
      end
      if (state_r == BS_DIV_WAIT && ds_rsp.done) begin
        j_r <= j_r + 3'd1;
      end
      if (state_r == BS_EMIT && out_free) begin
        k_r <= k_r + 2'd1;
      end
      if (state_r == BS_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    psh  = prod_r >>> FRAC_BITS;
    subw = acc_r - 66'(prod_r);
  end

  // Multiplier and product writeback
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (tag_r.op)
      WB_LD:     acc_r <= 66'(prod_r);
      WB_ADD:    acc_r <= acc_r + 66'(prod_r);
      WB_SUB:    acc_r <= subw;
      WB_LD_SH:  acc_r <= 66'(psh);
      WB_ADD_SH: acc_r <= acc_r + 66'(psh);
      WB_U:      u_r[tag_r.idx] <= 64'(tg_r[tag_r.idx]) - psh;
      WB_SUBW: begin
        acc_r          <= subw;
        w_r[tag_r.idx] <= sat32(subw >>> FRAC_BITS);
      end
      default: acc_r <= acc_r;
    endcase
  end

  // Datapath registers stepped by the sequencer
  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: begin
        if (!q_empty) tri_r <= q_head;
      end
      BS_EDGE: begin
        for (int c = 0; c < 3; c++) begin
          e1_r[c] <= sat_diff(pos[1][c], pos[0][c]);
          e2_r[c] <= sat_diff(pos[2][c], pos[0][c]);
        end
        s1_r <= sat_diff(tex[1][0], tex[0][0]);
        t1_r <= sat_diff(tex[1][1], tex[0][1]);
        s2_r <= sat_diff(tex[2][0], tex[0][0]);
        t2_r <= sat_diff(tex[2][1], tex[0][1]);
      end
      BS_DET_CHK: begin
        det_r <= acc_r;
        deg_r <= (acc_r == '0);
        if (acc_r == '0) begin
          for (int c = 0; c < 3; c++) begin
            tg_r[c] <= '0;
            bt_r[c] <= '0;
          end
        end
      end
      BS_DIV_GO: begin
        qneg_r <= acc_r[65] ^ det_r[65];
      end
      BS_DIV_WAIT: begin
        if (ds_rsp.done) begin
          if (j_r < 3'd3) tg_r[jc] <= qval;
          else            bt_r[jc] <= qval;
        end
      end
      BS_DSAT: begin
        d_r <= sat32(acc_r);
      end
      BS_MAG: begin
        for (int c = 0; c < 3; c++) begin
          m_r[c]    <= u_r[c][63] ? 64'(-u_r[c]) : 64'(u_r[c]);
          mneg_r[c] <= u_r[c][63];
        end
      end
      BS_SHIFT: begin
        // Common right shift until every magnitude is below 2^30.
        if (big) begin
          for (int c = 0; c < 3; c++) m_r[c] <= m_r[c] >> 1;
        end
      end
      BS_SQ_CHK: begin
        if (acc_r == '0) begin
          for (int c = 0; c < 3; c++) h_r[c] <= '0;
        end
      end
      BS_SQRT: begin
        if (ds_rsp.done) len_r <= ds_rsp.result[30:0];
      end
      BS_NRM_WAIT: begin
        if (ds_rsp.done) h_r[c_idx] <= nq;
      end
      BS_EMIT: begin
        if (out_free) begin
          out_r.tan_x      <= acc_r[65] ? -h_r[0] : h_r[0];
          out_r.tan_y      <= acc_r[65] ? -h_r[1] : h_r[1];
          out_r.tan_z      <= acc_r[65] ? -h_r[2] : h_r[2];
          out_r.bitan_x    <= bt_r[0];
          out_r.bitan_y    <= bt_r[1];
          out_r.bitan_z    <= bt_r[2];
          out_r.degenerate <= deg_r;
          out_r.last       <= (k_r == 2'd2);
        end
      end
      default: begin
        d_r <= d_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/triangle_tangent_basis_top.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis_top: per-vertex tangent space for triangle lists
// Collects vertices three at a time and returns one tangent/bitangent
// result per vertex once the triangle is complete.
// ----------------------------------------------------------------------------
// Usage: vertices enter on the in_ channel (valid/ready), one transfer per
// vertex, in Q-format with FRAC_BITS fraction bits. The first two vertices
// of a triangle produce nothing; after the third, three results leave on
// the out_ channel in arrival order, last set on the third.
// A collector stores vertices and hands complete triangles to a two-entry
// queue, so up to two further triangles can be taken in while one is
// being processed. The sequencer behind it uses one 32x32 multiplier and a
// shared iterative divide/root unit that resolves one bit per cycle.
// Per triangle: six quotients of 32 steps, none for a zero determinant. Per
// vertex: one 32-step root and three quotients of FRAC_BITS+1 steps, after
// a common right shift of the tangent magnitudes.
// Reset (rst_n low at a clock edge) empties the collector and the queue.
// A stalled receiver holds the result register; the sequencer then waits,
// and input stalls once the queue is full.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_top import ttb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ttb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ttb_out_t out_data
);

  logic     q_push;
  ttb_tri_t q_data;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  ttb_tri_t q_head;
  ds_req_t  ds_req;
  ds_rsp_t  ds_rsp;

  ttb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_data),
    .q_full   (q_full)
  );

  ttb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ttb_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .rsp   (ds_rsp)
  );

  ttb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ds_req    (ds_req),
    .ds_rsp    (ds_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### bench/ttb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttb_checker: tangent basis predictor and result comparator
// Collects every vertex transfer into triangles, works out the three
// per-vertex tangent/bitangent results and compares each result transfer
// against the oldest one still owed.
// ----------------------------------------------------------------------------
module ttb_checker import ttb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  ttb_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  ttb_out_t out_data,
  output int       err_cnt,
  output int       owed_cnt,
  output int       tri_cnt,
  output int       result_cnt,
  output int       degen_cnt
);

  ttb_out_t tangent_q[$];
  ttb_in_t  corner[3];
  int       corner_idx;
  int       pushed;

  assign owed_cnt = pushed - result_cnt;

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Quotient with FRAC_BITS fraction bits, truncated toward zero, saturated.
  function automatic longint frac_quotient(input logic signed [127:0] num,
                                           input logic signed [127:0] den);
    logic [127:0] un, ud, m, lim;
    logic         neg;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? -num : num;
    ud  = (den < 0) ? -den : den;
    lim = neg ? 128'd2147483648 : 128'd2147483647;
    m   = (un << FRAC_BITS) / ud;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic predict_triangle();
    longint p[3][3], nv[3], u[3], h[3], w[3], tg[3], bt[3], d, s;
    longint uvs[3][2];
    logic signed [127:0] e1[3], e2[3], s1, t1, s2, t2, det;
    longint unsigned mg[3], mx, sum, len;
    int sh;
    ttb_out_t r;
    for (int k = 0; k < 3; k++) begin
      p[k][0] = corner[k].pos_x;
      p[k][1] = corner[k].pos_y;
      p[k][2] = corner[k].pos_z;
      uvs[k][0] = corner[k].tex_u;
      uvs[k][1] = corner[k].tex_v;
    end
    for (int c = 0; c < 3; c++) begin
      e1[c] = clamp32(p[1][c] - p[0][c]);
      e2[c] = clamp32(p[2][c] - p[0][c]);
    end
    s1 = clamp32(uvs[1][0] - uvs[0][0]);
    t1 = clamp32(uvs[1][1] - uvs[0][1]);
    s2 = clamp32(uvs[2][0] - uvs[0][0]);
    t2 = clamp32(uvs[2][1] - uvs[0][1]);
    det = s1 * t2 - t1 * s2;
    for (int c = 0; c < 3; c++) begin
      if (det == 0) begin
        tg[c] = 0;
        bt[c] = 0;
      end else begin
        tg[c] = frac_quotient(e1[c] * t2 - e2[c] * t1, det);
        bt[c] = frac_quotient(e2[c] * s1 - e1[c] * s2, det);
      end
    end
    if (det == 0) degen_cnt++;
    for (int k = 0; k < 3; k++) begin
      nv[0] = corner[k].norm_x;
      nv[1] = corner[k].norm_y;
      nv[2] = corner[k].norm_z;
      d = 0;
      for (int c = 0; c < 3; c++) d += (nv[c] * tg[c]) >>> FRAC_BITS;
      d = clamp32(d);
      for (int c = 0; c < 3; c++) u[c] = tg[c] - ((nv[c] * d) >>> FRAC_BITS);
      // Scale down so the sum of squares fits before taking the root.
      mx = 0;
      for (int c = 0; c < 3; c++) begin
        mg[c] = (u[c] < 0) ? -u[c] : u[c];
        if (mg[c] > mx) mx = mg[c];
      end
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        mg[c] = mg[c] >> sh;
        sum += mg[c] * mg[c];
      end
      if (sum == 0) begin
        for (int c = 0; c < 3; c++) h[c] = 0;
      end else begin
        len = int_sqrt(sum);
        for (int c = 0; c < 3; c++) begin
          h[c] = longint'((mg[c] << FRAC_BITS) / len);
          if (u[c] < 0) h[c] = -h[c];
        end
      end
      w[0] = clamp32((nv[1] * h[2] - nv[2] * h[1]) >>> FRAC_BITS);
      w[1] = clamp32((nv[2] * h[0] - nv[0] * h[2]) >>> FRAC_BITS);
      w[2] = clamp32((nv[0] * h[1] - nv[1] * h[0]) >>> FRAC_BITS);
      s = 0;
      for (int c = 0; c < 3; c++) s += (w[c] * bt[c]) >>> FRAC_BITS;
      if (s < 0) begin
        for (int c = 0; c < 3; c++) h[c] = -h[c];
      end
      r.tan_x      = h[0][31:0];
      r.tan_y      = h[1][31:0];
      r.tan_z      = h[2][31:0];
      r.bitan_x    = bt[0][31:0];
      r.bitan_y    = bt[1][31:0];
      r.bitan_z    = bt[2][31:0];
      r.degenerate = (det == 0);
      r.last       = (k == 2);
      tangent_q = {tangent_q, r};
      pushed++;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("%0t: MISMATCH result %0d %s got %h want %h", $realtime, result_cnt,
             what, got, want);
    err_cnt++;
  endtask

  initial begin
    err_cnt    = 0;
    tri_cnt    = 0;
    result_cnt = 0;
    degen_cnt  = 0;
    pushed     = 0;
    corner_idx = 0;
  end

  always @(posedge clk) begin
    ttb_out_t want;
    if (rst_n && in_valid && in_ready) begin
      corner[corner_idx] = in_data;
      if (corner_idx == 2) begin
        corner_idx = 0;
        tri_cnt++;
        predict_triangle();
      end else begin
        corner_idx++;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (tangent_q.size() == 0) begin
        $display("%0t: MISMATCH result transfer with nothing owed", $realtime);
        err_cnt++;
      end else begin
        want = tangent_q.pop_front();
        if (out_data.tan_x !== want.tan_x) report("tan_x", out_data.tan_x, want.tan_x);
        if (out_data.tan_y !== want.tan_y) report("tan_y", out_data.tan_y, want.tan_y);
        if (out_data.tan_z !== want.tan_z) report("tan_z", out_data.tan_z, want.tan_z);
        if (out_data.bitan_x !== want.bitan_x)
          report("bitan_x", out_data.bitan_x, want.bitan_x);
        if (out_data.bitan_y !== want.bitan_y)
          report("bitan_y", out_data.bitan_y, want.bitan_y);
        if (out_data.bitan_z !== want.bitan_z)
          report("bitan_z", out_data.bitan_z, want.bitan_z);
        if (out_data.degenerate !== want.degenerate)
          report("degenerate", 32'(out_data.degenerate), 32'(want.degenerate));
        if (out_data.last !== want.last)
          report("last", 32'(out_data.last), 32'(want.last));
      end
      result_cnt++;
    end
  end

endmodule

### bench/tb_triangle_tangent_basis_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_basis_top: testbench of the triangle tangent basis block
// Feeds directed and random triangles through the vertex channel with bursty
// timing, stalls the result channel (once for a long stretch) and leaves
// prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_basis_top;
  import ttb_pkg::*;

  localparam int  ONE         = 32'sh0001_0000;
  localparam int  IDLE_LIMIT  = 20000;
  localparam int  RAND_TRIS   = 78;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ttb_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ttb_out_t out_data;
  logic     hold_off;
  int       err_cnt, owed_cnt, tri_cnt, result_cnt, degen_cnt;
  int       sent_cnt;
  int       idle_cycles;
  int       burst_left;

  triangle_tangent_basis_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ttb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .err_cnt    (err_cnt),
    .owed_cnt   (owed_cnt),
    .tri_cnt    (tri_cnt),
    .result_cnt (result_cnt),
    .degen_cnt  (degen_cnt)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic ttb_in_t vertex(input int px, py, pz, u, v, nx, ny, nz);
    ttb_in_t t;
    t.pos_x = px; t.pos_y = py; t.pos_z = pz;
    t.tex_u = u;  t.tex_v = v;
    t.norm_x = nx; t.norm_y = ny; t.norm_z = nz;
    return t;
  endfunction

  // Mode 0: modest geometry, mode 1: any 32-bit value, mode 2: small values.
  function automatic int pick(input int mode);
    case (mode)
      0:       return $signed($urandom_range(0, 2 * 8 * ONE)) - 8 * ONE;
      1:       return $urandom;
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic int pick_normal(input int mode);
    if (mode == 1) return $urandom;
    return $signed($urandom_range(0, 2 * ONE)) - ONE;
  endfunction

  task automatic send(input ttb_in_t v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent_cnt++;
  endtask

  task automatic send_triangle(input int mode, input bit flat_uv);
    int u0, v0;
    u0 = pick(mode);
    v0 = pick(mode);
    for (int k = 0; k < 3; k++) begin
      send(vertex(pick(mode), pick(mode), pick(mode),
                  flat_uv ? u0 : pick(mode), flat_uv ? v0 + k * 0 : pick(mode),
                  pick_normal(mode), pick_normal(mode), pick_normal(mode)));
    end
  endtask

  // Receiver: stall patterns that change now and then, plus the long hold-off.
  always @(posedge clk) begin
    int pattern;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      pattern = (sent_cnt / 20) % 4;
      case (pattern)
        0:       out_ready <= !hold_off;
        1:       out_ready <= !hold_off && ($urandom_range(0, 1) == 1);
        2:       out_ready <= !hold_off && ($urandom_range(0, 4) == 0);
        default: out_ready <= !hold_off && ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  initial begin
    hold_off <= 1'b0;
    wait (sent_cnt >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (4000) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int mode;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    sent_cnt    = 0;
    burst_left  = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unit right triangle, positive handedness.
    send(vertex(0, 0, 0, 0, 0, 0, 0, ONE));
    send(vertex(ONE, 0, 0, ONE, 0, 0, 0, ONE));
    send(vertex(0, ONE, 0, 0, ONE, 0, 0, ONE));
    // Mirrored texture space flips the tangent.
    send(vertex(0, 0, 0, 0, 0, 0, 0, ONE));
    send(vertex(ONE, 0, 0, ONE, 0, 0, 0, ONE));
    send(vertex(0, ONE, 0, 0, -ONE, 0, 0, ONE));
    // Zero texture determinant.
    send(vertex(0, 0, 0, ONE, ONE, 0, ONE, 0));
    send(vertex(ONE, 0, 0, ONE, ONE, 0, ONE, 0));
    send(vertex(0, ONE, ONE, ONE, ONE, 0, ONE, 0));
    // Coincident positions give a zero tangent to normalize.
    send(vertex(ONE, ONE, ONE, 0, 0, 0, 0, ONE));
    send(vertex(ONE, ONE, ONE, ONE, 0, 0, 0, ONE));
    send(vertex(ONE, ONE, ONE, 0, ONE, 0, 0, ONE));
    // Normal along the tangent leaves nothing after orthogonalization.
    send(vertex(0, 0, 0, 0, 0, ONE, 0, 0));
    send(vertex(ONE, 0, 0, ONE, 0, ONE, 0, 0));
    send(vertex(0, ONE, 0, 0, ONE, ONE, 0, 0));
    // Field extremes: saturating edges and quotients.
    send(vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send(vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    send(vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff));
    // Tiny determinant with large edges.
    send(vertex(0, 0, 0, 0, 0, 0, ONE, 0));
    send(vertex(32'h7fff_ffff, 0, 32'h8000_0000, 1, 0, 0, ONE, 0));
    send(vertex(0, 32'h7fff_ffff, 0, 0, 1, 32'hffff_ffff, 0, 32'hffff_ffff));

    for (int i = 0; i < RAND_TRIS; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) send_triangle(0, 1'b0);
      else if (mode < 8) send_triangle(1, 1'b0);
      else if (mode < 9) send_triangle(2, 1'b0);
      else send_triangle($urandom_range(0, 1), 1'b1);
    end
    in_valid <= 1'b0;

    // Let the checker take in the closing vertex before polling what is owed.
    @(posedge clk);
    while (owed_cnt != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d vertices in %0d triangles (%0d degenerate), %0d results checked.",
             sent_cnt, tri_cnt, degen_cnt, result_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
sv/ttb_pkg.sv
sv/ttb_front.sv
sv/ttb_queue.sv
sv/ttb_divsqrt.sv
sv/ttb_back.sv
sv/triangle_tangent_basis_top.sv
bench/ttb_checker.sv
bench/tb_triangle_tangent_basis_top.sv
